// ===== sv/pad_pkg.sv =====
package pad_pkg;

    // Field widths
    localparam int COORD_W    = 10;
    localparam int ANG_W      = 17;

    // CORDIC datapath
    localparam int ITERATIONS = 16;
    localparam int TABLE_LEN  = 24;
    localparam int IDX_W      = $clog2(TABLE_LEN);
    localparam int ANG_FRAC   = 24;
    localparam int FRAC_BITS  = 8;
    localparam int PRESHIFT   = 16;
    localparam int XY_W       = COORD_W + PRESHIFT + 3;
    localparam int Z_W        = 33;
    localparam int TOT_W      = 34;
    localparam int DROP       = ANG_FRAC - FRAC_BITS;
    localparam int RND_W      = TOT_W - DROP;

    localparam logic [COORD_W-1:0] CENTER_RESET = COORD_W'(300);

    // Angles in degrees, Q.24
    localparam logic signed [Z_W-1:0] DEG45   = Z_W'(45) <<< ANG_FRAC;
    localparam logic signed [Z_W-1:0] DEG90   = Z_W'(90) <<< ANG_FRAC;
    localparam logic [TOT_W-1:0]      DEG180  = TOT_W'(180) << ANG_FRAC;
    localparam logic [TOT_W-1:0]      DEG360  = TOT_W'(360) << ANG_FRAC;
    localparam logic [TOT_W-1:0]      HALF_LSB = TOT_W'(1) << (DROP - 1);
    localparam logic [RND_W-1:0]      FULL_TURN = RND_W'(360) << FRAC_BITS;

    typedef enum logic [1:0] {
        QUAD_I,
        QUAD_II,
        QUAD_III,
        QUAD_IV
    } quad_t;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   swapped;
        quad_t                  quad;
        logic                   at_center;
    } cell_data_t;

    // atan(2^-i) in degrees, Q.24, rounded to nearest
    function automatic logic [31:0] atan_entry(input logic [IDX_W-1:0] idx);
        logic [31:0] t;
        case (idx)
            5'd0:    t = 32'd754974720;
            5'd1:    t = 32'd445687602;
            5'd2:    t = 32'd235489088;
            5'd3:    t = 32'd119537938;
            5'd4:    t = 32'd60000934;
            5'd5:    t = 32'd30029717;
            5'd6:    t = 32'd15018523;
            5'd7:    t = 32'd7509720;
            5'd8:    t = 32'd3754917;
            5'd9:    t = 32'd1877466;
            5'd10:   t = 32'd938734;
            5'd11:   t = 32'd469367;
            5'd12:   t = 32'd234684;
            5'd13:   t = 32'd117342;
            5'd14:   t = 32'd58671;
            5'd15:   t = 32'd29335;
            5'd16:   t = 32'd14668;
            5'd17:   t = 32'd7334;
            5'd18:   t = 32'd3667;
            5'd19:   t = 32'd1833;
            5'd20:   t = 32'd917;
            5'd21:   t = 32'd458;
            5'd22:   t = 32'd229;
            5'd23:   t = 32'd115;
            default: t = 32'd0;
        endcase
        return t;
    endfunction

endpackage

// ===== sv/pad_prep.sv =====
module pad_prep
    import pad_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               in_valid,
    input  logic [COORD_W-1:0] x_coord,
    input  logic [COORD_W-1:0] y_coord,
    input  logic [COORD_W-1:0] center,
    output logic               out_valid,
    output cell_data_t         out_data
);

    logic signed [COORD_W:0] dx;
    logic signed [COORD_W:0] dy;
    logic [COORD_W-1:0]      ax;
    logic [COORD_W-1:0]      ay;
    logic [COORD_W-1:0]      big;
    logic [COORD_W-1:0]      lit;
    logic                    valid_reg;
    cell_data_t              data_reg;
    cell_data_t              data_next;

    // Form offsets from the center, fold to the first octant
    always_comb
    begin
        dx = $signed({1'b0, x_coord}) - $signed({1'b0, center});
        dy = $signed({1'b0, center}) - $signed({1'b0, y_coord});
        ax = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
        ay = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
        data_next.swapped = (ay > ax);
        big = data_next.swapped ? ay : ax;
        lit = data_next.swapped ? ax : ay;
        data_next.x = XY_W'({big, {PRESHIFT{1'b0}}});
        data_next.y = XY_W'({lit, {PRESHIFT{1'b0}}});
        data_next.z = '0;
        data_next.at_center = (dx == '0) && (dy == '0);
        if (!dx[COORD_W] && !dy[COORD_W])
        begin
            data_next.quad = QUAD_I;
        end
        else if (dx[COORD_W] && !dy[COORD_W])
        begin
            data_next.quad = QUAD_II;
        end
        else if (dx[COORD_W] || dx == '0)
        begin
            data_next.quad = QUAD_III;
        end
        else
        begin
            data_next.quad = QUAD_IV;
        end
    end

    // Advance valid with the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    // Hold payload unless the pipeline moves
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== sv/pad_cell.sv =====
module pad_cell
    import pad_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic [IDX_W-1:0] idx,
    input  logic             in_valid,
    input  cell_data_t       in_data,
    output logic             out_valid,
    output cell_data_t       out_data
);

    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    logic signed [Z_W-1:0]  t_ext;
    logic                   valid_reg;
    cell_data_t             data_reg;
    cell_data_t             data_next;

    // One vectoring step: rotate toward the x axis, accumulate the angle
    always_comb
    begin
        xs = in_data.x >>> idx;
        ys = in_data.y >>> idx;
        t_ext = Z_W'(atan_entry(idx));
        data_next = in_data;
        if (in_data.y == '0)
        begin
            data_next = in_data;
        end
        else if (!in_data.y[XY_W-1])
        begin
            data_next.x = in_data.x + ys;
            data_next.y = in_data.y - xs;
            data_next.z = in_data.z + t_ext;
        end
        else
        begin
            data_next.x = in_data.x - ys;
            data_next.y = in_data.y + xs;
            data_next.z = in_data.z - t_ext;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== sv/pad_finish.sv =====
module pad_finish
    import pad_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             in_valid,
    input  cell_data_t       in_data,
    output logic             out_valid,
    output logic [ANG_W-1:0] angle_deg,
    output logic             at_center
);

    logic signed [Z_W-1:0] zc;
    logic signed [Z_W-1:0] zs;
    logic [TOT_W-1:0]      zu;
    logic [TOT_W-1:0]      total_next;
    logic [TOT_W-1:0]      total_reg;
    logic                  center_a_reg;
    logic                  valid_a_reg;
    logic [TOT_W-1:0]      rsum;
    logic [RND_W-1:0]      rnd;
    logic [ANG_W-1:0]      angle_next;
    logic [ANG_W-1:0]      angle_reg;
    logic                  center_reg;
    logic                  valid_reg;

    // Clamp to the octant, unfold the swap, place in the quadrant
    always_comb
    begin
        if (in_data.z[Z_W-1])
        begin
            zc = '0;
        end
        else if (in_data.z > DEG45)
        begin
            zc = DEG45;
        end
        else
        begin
            zc = in_data.z;
        end
        zs = in_data.swapped ? (DEG90 - zc) : zc;
        zu = TOT_W'(unsigned'(zs));
        case (in_data.quad)
            QUAD_I:   total_next = zu;
            QUAD_II:  total_next = DEG180 - zu;
            QUAD_III: total_next = DEG180 + zu;
            QUAD_IV:  total_next = DEG360 - zu;
            default:  total_next = zu;
        endcase
    end

    // Round to nearest, wrap a full turn to zero, force zero at the center
    always_comb
    begin
        rsum = total_reg + HALF_LSB;
        rnd = rsum[TOT_W-1:DROP];
        if (center_a_reg || rnd >= FULL_TURN)
        begin
            angle_next = '0;
        end
        else
        begin
            angle_next = rnd[ANG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_reg   <= 1'b0;
        end
        else if (adv)
        begin
            valid_a_reg <= in_valid;
            valid_reg   <= valid_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            total_reg    <= total_next;
            center_a_reg <= in_data.at_center;
            angle_reg    <= angle_next;
            center_reg   <= center_a_reg;
        end
    end

    assign out_valid = valid_reg;
    assign angle_deg = angle_reg;
    assign at_center = center_reg;

endmodule

// ===== sv/point_angle_degrees.sv =====
// Angle of a screen point around a configurable center, counter-clockwise from
// the positive x axis with screen y growing downward, given in degrees times 256
// (0 up to 92159), rounded to nearest; the center point itself gives angle 0
// with at_center set. The datapath is a 16-cell CORDIC pipeline between an
// input fold stage and a two-stage round/unfold stage, so a new item is taken
// every cycle while the pipeline advances; the whole pipeline holds while a
// result waits under out_stall. The center register (reset 300) is written
// through cfg_valid/cfg_ready, which is always ready, and should only be
// changed while no items are in flight.
module point_angle_degrees
    import pad_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [COORD_W-1:0] center,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [COORD_W-1:0] x_coord,
    input  logic [COORD_W-1:0] y_coord,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [ANG_W-1:0]   angle_deg,
    output logic               at_center
);

    logic [COORD_W-1:0] center_reg;
    logic               adv;
    logic               valid_chain [0:ITERATIONS];
    cell_data_t         data_chain  [0:ITERATIONS];

    // Move the whole pipeline unless a result is held at the output
    assign adv       = !out_valid || !out_stall;
    assign in_stall  = !adv;
    assign cfg_ready = 1'b1;

    // Center register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg <= CENTER_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            center_reg <= center;
        end
    end

    pad_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (in_valid),
        .x_coord   (x_coord),
        .y_coord   (y_coord),
        .center    (center_reg),
        .out_valid (valid_chain[0]),
        .out_data  (data_chain[0])
    );

    for (genvar i = 0; i < ITERATIONS; i++)
    begin : g_cell
        pad_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .idx       (IDX_W'(i)),
            .in_valid  (valid_chain[i]),
            .in_data   (data_chain[i]),
            .out_valid (valid_chain[i+1]),
            .out_data  (data_chain[i+1])
        );
    end

    pad_finish u_finish (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (valid_chain[ITERATIONS]),
        .in_data   (data_chain[ITERATIONS]),
        .out_valid (out_valid),
        .angle_deg (angle_deg),
        .at_center (at_center)
    );

endmodule

// ===== sv/pad_checker.sv =====
module pad_checker
    import pad_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic [ANG_W-1:0]   angle_deg,
    input logic               at_center
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(angle_deg) && $stable(at_center))
        else $error("stalled result changed");

    // Center point reports angle zero
    a_center_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && at_center |-> angle_deg == '0)
        else $error("center point with nonzero angle");

    // Angle stays below a full turn
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> angle_deg < ANG_W'(92160))
        else $error("angle reached full turn");

    // Input stalls only behind a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a held result");

endmodule

bind point_angle_degrees pad_checker u_pad_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .angle_deg (angle_deg),
    .at_center (at_center)
);

// ===== tb/point_angle_checker.sv =====
`timescale 1ns / 1ps

module point_angle_checker
    import pad_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [COORD_W-1:0] center,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [COORD_W-1:0] x_coord,
    input  logic [COORD_W-1:0] y_coord,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [ANG_W-1:0]   angle_deg,
    input  logic               at_center,
    output int                 fail_count,
    output int                 in_flight
);

    // atan(2^-i) in degrees, Q.24
    localparam longint ATAN_Q24 [0:23] = '{
        754974720, 445687602, 235489088, 119537938,
        60000934, 30029717, 15018523, 7509720,
        3754917, 1877466, 938734, 469367,
        234684, 117342, 58671, 29335,
        14668, 7334, 3667, 1833,
        917, 458, 229, 115
    };

    localparam longint Q45  = longint'(45) <<< ANG_FRAC;
    localparam longint Q90  = longint'(90) <<< ANG_FRAC;
    localparam longint Q180 = longint'(180) <<< ANG_FRAC;
    localparam longint Q360 = longint'(360) <<< ANG_FRAC;

    typedef struct packed {
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        logic [ANG_W-1:0]   angle;
        logic               flag;
    } angle_entry_t;

    angle_entry_t       pending_angles[$];
    logic [COORD_W-1:0] center_copy;
    int                 angle_errors;

    assign fail_count = angle_errors;

    // Fold to the first octant, run the vectoring steps, unfold and round
    function automatic angle_entry_t predict_angle(input logic [COORD_W-1:0] ctr,
                                                   input logic [COORD_W-1:0] px,
                                                   input logic [COORD_W-1:0] py);
        longint       dx, dy, ax, ay, xr, yr, zr, xs, ys, total, rnd, tmp;
        bit           swapped;
        quad_t        quad;
        int           i;
        angle_entry_t res;
        dx = longint'(px) - longint'(ctr);
        dy = longint'(ctr) - longint'(py);
        res.px = px;
        res.py = py;
        if (dx == 0 && dy == 0)
        begin
            res.angle = '0;
            res.flag  = 1'b1;
            return res;
        end
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        swapped = 1'b0;
        if (ay > ax)
        begin
            tmp = ax;
            ax = ay;
            ay = tmp;
            swapped = 1'b1;
        end
        xr = ax <<< PRESHIFT;
        yr = ay <<< PRESHIFT;
        zr = 0;
        for (i = 0; i < ITERATIONS; i++)
        begin
            if (yr == 0)
                break;
            xs = xr >>> i;
            ys = yr >>> i;
            if (yr > 0)
            begin
                xr = xr + ys;
                yr = yr - xs;
                zr = zr + ATAN_Q24[i];
            end
            else
            begin
                xr = xr - ys;
                yr = yr + xs;
                zr = zr - ATAN_Q24[i];
            end
        end
        if (zr < 0)
            zr = 0;
        if (zr > Q45)
            zr = Q45;
        if (swapped)
            zr = Q90 - zr;
        if (dx >= 0 && dy >= 0)
            quad = QUAD_I;
        else if (dx < 0 && dy >= 0)
            quad = QUAD_II;
        else if (dx <= 0)
            quad = QUAD_III;
        else
            quad = QUAD_IV;
        case (quad)
            QUAD_I:   total = zr;
            QUAD_II:  total = Q180 - zr;
            QUAD_III: total = Q180 + zr;
            default:  total = Q360 - zr;
        endcase
        rnd = (total + (longint'(1) <<< (DROP - 1))) >>> DROP;
        // wrap a full turn back to zero
        if (rnd >= (longint'(360) <<< FRAC_BITS))
            rnd = 0;
        res.angle = rnd[ANG_W-1:0];
        res.flag  = 1'b0;
        return res;
    endfunction

    // Track the center, queue predictions, compare results in order
    always @(posedge clk or negedge rst_n)
    begin
        angle_entry_t want;
        if (!rst_n)
        begin
            center_copy = CENTER_RESET;
            pending_angles.delete();
            angle_errors = 0;
            in_flight <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_angles.size() == 0)
                begin
                    $display("%0t: unexpected result angle_deg=%0d at_center=%0d",
                             $time, angle_deg, at_center);
                    angle_errors++;
                end
                else
                begin
                    want = pending_angles.pop_front();
                    if (angle_deg !== want.angle)
                    begin
                        $display("%0t: point (%0d,%0d) angle_deg expected %0d actual %0d",
                                 $time, want.px, want.py, want.angle, angle_deg);
                        angle_errors++;
                    end
                    if (at_center !== want.flag)
                    begin
                        $display("%0t: point (%0d,%0d) at_center expected %0d actual %0d",
                                 $time, want.px, want.py, want.flag, at_center);
                        angle_errors++;
                    end
                end
            end
            if (in_valid && !in_stall)
                pending_angles.push_back(predict_angle(center_copy, x_coord, y_coord));
            if (cfg_valid && cfg_ready)
                center_copy = center;
            in_flight <= pending_angles.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import pad_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int SEG_ITEMS    = 208;
    localparam int DRAIN_CYCLES = 40;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [COORD_W-1:0] center;
    logic               in_valid;
    logic               in_stall;
    logic [COORD_W-1:0] x_coord;
    logic [COORD_W-1:0] y_coord;
    logic               out_valid;
    logic               out_stall;
    logic [ANG_W-1:0]   angle_deg;
    logic               at_center;

    int                 fail_count;
    int                 in_flight;
    int                 cycle_count;
    int                 send_idle;
    int                 recv_idle;
    logic [COORD_W-1:0] cur_center;

    point_angle_degrees u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .center    (center),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .x_coord   (x_coord),
        .y_coord   (y_coord),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .angle_deg (angle_deg),
        .at_center (at_center)
    );

    point_angle_checker u_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .center     (center),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .x_coord    (x_coord),
        .y_coord    (y_coord),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .angle_deg  (angle_deg),
        .at_center  (at_center),
        .fail_count (fail_count),
        .in_flight  (in_flight)
    );

    // Clock
    always #5 clk = ~clk;

    // Random backpressure on the result side
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_idle);
    end

    // Give up on a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("point_angle_degrees regression: fail");
            $finish;
        end
    end

    // Offer one point, with a random gap first, and hold until accepted
    task automatic send_point(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        x_coord  <= px;
        y_coord  <= py;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Drop valid and wait until every queued result has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (in_flight != 0);
    endtask

    task automatic write_center(input logic [COORD_W-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        center    <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid  <= 1'b0;
        cur_center = value;
    endtask

    // Mostly random points, plus near-center, center, axis, diagonal and corner points
    task automatic pick_point(output logic [COORD_W-1:0] px, output logic [COORD_W-1:0] py);
        int sel;
        int d;
        sel = $urandom_range(99);
        if (sel < 50)
        begin
            px = COORD_W'($urandom);
            py = COORD_W'($urandom);
        end
        else if (sel < 65)
        begin
            px = cur_center + COORD_W'($urandom_range(8)) - COORD_W'(4);
            py = cur_center + COORD_W'($urandom_range(8)) - COORD_W'(4);
        end
        else if (sel < 75)
        begin
            px = COORD_W'($urandom);
            py = COORD_W'($urandom);
            if ($urandom_range(1))
                px = cur_center;
            else
                py = cur_center;
        end
        else if (sel < 85)
        begin
            d  = $urandom_range(511);
            px = $urandom_range(1) ? cur_center + COORD_W'(d) : cur_center - COORD_W'(d);
            py = $urandom_range(1) ? cur_center + COORD_W'(d) : cur_center - COORD_W'(d);
        end
        else if (sel < 90)
        begin
            px = cur_center;
            py = cur_center;
        end
        else
        begin
            px = $urandom_range(1) ? '1 : '0;
            py = $urandom_range(1) ? '1 : '0;
        end
    endtask

    initial
    begin
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        logic [COORD_W-1:0] seg_center;
        int                 seg;
        int                 n;
        clk         = 1'b0;
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        center      = '0;
        in_valid    = 1'b0;
        x_coord     = '0;
        y_coord     = '0;
        out_stall   = 1'b0;
        cycle_count = 0;
        send_idle   = 36;
        recv_idle   = 49;
        cur_center  = CENTER_RESET;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed points around the reset center
        send_point(10'd300, 10'd300);
        send_point(10'd1023, 10'd300);
        send_point(10'd300, 10'd0);
        send_point(10'd0, 10'd300);
        send_point(10'd300, 10'd1023);
        send_point(10'd400, 10'd200);
        send_point(10'd200, 10'd200);
        send_point(10'd200, 10'd400);
        send_point(10'd400, 10'd400);
        send_point(10'd0, 10'd0);
        send_point(10'd1023, 10'd1023);
        send_point(10'd0, 10'd1023);
        send_point(10'd1023, 10'd0);
        send_point(10'd1023, 10'd299);
        send_point(10'd1023, 10'd301);
        send_point(10'd301, 10'd1023);
        send_point(10'd299, 10'd0);

        // Extreme centers with their corners
        write_center(10'd0);
        send_point(10'd0, 10'd0);
        send_point(10'd1023, 10'd1);
        send_point(10'd1023, 10'd1023);
        write_center(10'd1023);
        send_point(10'd1023, 10'd1023);
        send_point(10'd0, 10'd0);
        send_point(10'd0, 10'd1022);

        // Random segments: new center each, idling pattern changes every two
        for (seg = 0; seg < 6; seg++)
        begin
            case (seg)
                0:       seg_center = 10'd0;
                1:       seg_center = 10'd1023;
                3:       seg_center = 10'd1;
                4:       seg_center = 10'd1022;
                default: seg_center = COORD_W'($urandom);
            endcase
            write_center(seg_center);
            if (seg < 2)
            begin
                send_idle = 36;
                recv_idle = 49;
            end
            else if (seg < 4)
            begin
                send_idle = 49;
                recv_idle = 36;
            end
            else
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            for (n = 0; n < SEG_ITEMS; n++)
            begin
                pick_point(px, py);
                send_point(px, py);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && in_flight == 0)
            $display("point_angle_degrees regression: pass");
        else
            $display("point_angle_degrees regression: fail");
        $finish;
    end

endmodule
